### design/code_line_filter_dedup_defines.svh
// ----------------------------------------------------------------------------
// code_line_filter_dedup_defines
// assertion macros used by the scanner line filter core
// ----------------------------------------------------------------------------
`ifndef CODE_LINE_FILTER_DEDUP_DEFINES_SVH
`define CODE_LINE_FILTER_DEDUP_DEFINES_SVH

// condition that holds at every clock edge outside reset
`define CLFD_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence that holds in the cycle after the antecedent
`define CLFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/clfd_pkg.sv
// ----------------------------------------------------------------------------
// clfd_pkg
// types, constants and character helpers of the scanner line filter
// ----------------------------------------------------------------------------
package clfd_pkg;

	localparam int CODE_DEPTH_DEF = 64;
	localparam int LINE_LIMIT_DEF = 128;

	localparam logic [15:0] DUP_WINDOW_RST = 16'd700;
	localparam logic [6:0]  MIN_LEN_RST    = 7'd6;
	localparam logic [6:0]  MAX_LEN_RST    = 7'd64;

	localparam logic [7:0] CHAR_LO = 8'd32;
	localparam logic [7:0] CHAR_HI = 8'd126;
	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] CHAR_LF = 8'h0a;

	localparam logic [1:0] REG_DUP_WINDOW = 2'd0;
	localparam logic [1:0] REG_MIN_LEN    = 2'd1;
	localparam logic [1:0] REG_MAX_LEN    = 2'd2;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_DUP      = 2'd1,
		ST_BAD_LEN  = 2'd2,
		ST_BAD_CHAR = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_LEND,
		S_WOUT
	} state_t;

	typedef struct packed {
		logic [15:0] dup_window_ms;
		logic [6:0]  min_length;
		logic [6:0]  max_length;
	} cfg_t;

	function automatic logic is_printable(input logic [7:0] c);
		return (c >= CHAR_LO) && (c <= CHAR_HI);
	endfunction

	function automatic logic is_eol(input logic [7:0] c);
		return (c == CHAR_CR) || (c == CHAR_LF);
	endfunction

	// digits, letters and - _ . : /
	function automatic logic char_allowed(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
			(c >= 8'h61 && c <= 8'h7a) || c == 8'h2d || c == 8'h5f ||
			c == 8'h2e || c == 8'h3a || c == 8'h2f;
	endfunction

endpackage

### design/clfd_mem.sv
// ----------------------------------------------------------------------------
// clfd_mem
// code bank memory, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module clfd_mem #(
	parameter int DEPTH = 2 * clfd_pkg::CODE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/clfd_core.sv
// ----------------------------------------------------------------------------
// clfd_core
// line collection, code check and character walk over the code banks
// ----------------------------------------------------------------------------
`include "code_line_filter_dedup_defines.svh"

module clfd_core #(
	parameter int CODE_DEPTH = clfd_pkg::CODE_DEPTH_DEF,
	parameter int LINE_LIMIT = clfd_pkg::LINE_LIMIT_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  clfd_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          op,
	input  logic [7:0]    rx_byte,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    status,
	output logic [7:0]    code_char,
	output logic [7:0]    code_length,
	output logic [31:0]   time_ms,
	output logic          is_last
);
	import clfd_pkg::*;

	localparam int LCW  = $clog2(LINE_LIMIT + 1);
	localparam int LLW  = $clog2(CODE_DEPTH + 1);
	localparam int IW   = $clog2(CODE_DEPTH);
	localparam int AW   = $clog2(2 * CODE_DEPTH);
	localparam int W0   = (LCW > LLW) ? LCW : LLW;
	localparam int CMPW = (W0 > 7) ? W0 : 7;

	function automatic logic [AW-1:0] bank_addr(input logic b, input logic [IW-1:0] i);
		return b ? (AW'(CODE_DEPTH) + AW'(i)) : AW'(i);
	endfunction

	state_t          state_q, state_d;
	logic [LCW-1:0]  line_count_q;
	logic            chars_ok_q;
	logic            same_q;
	logic            last_bank_q;
	logic [LLW-1:0]  last_length_q;
	logic [31:0]     ms_q;
	logic [31:0]     last_time_q;
	logic [7:0]      byte_q;
	logic [LLW-1:0]  walk_q;

	logic            out_valid_q;
	status_t         status_q;
	logic [7:0]      char_q;
	logic [7:0]      len_q;
	logic [31:0]     time_q;
	logic            last_q;

	logic            mem_we, mem_re;
	logic [AW-1:0]   mem_waddr, mem_raddr;
	logic [7:0]      mem_rdata;

	logic            accept, out_free;
	logic            cnt_inc, bad_char, same_clr, clr_line, commit, walk_inc, tick;
	logic            load_out;
	status_t         out_status;
	logic [7:0]      out_char;
	logic            out_last;
	status_t         chk_status;
	logic [CMPW-1:0] len_w, maxl_w;
	logic [LLW-1:0]  walk_nx;
	logic            walk_last;
	logic            cur_bank;

	clfd_mem #(
		.DEPTH (2 * CODE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (rx_byte),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign cur_bank = ~last_bank_q;

	assign len_w     = CMPW'(line_count_q);
	assign maxl_w    = (CMPW'(cfg.max_length) > CMPW'(CODE_DEPTH)) ? CMPW'(CODE_DEPTH)
		: CMPW'(cfg.max_length);
	assign walk_nx   = walk_q + 1'b1;
	assign walk_last = (CMPW'(walk_nx) == len_w);

	always_comb begin
		if (len_w < CMPW'(cfg.min_length) || len_w > maxl_w) begin
			chk_status = ST_BAD_LEN;
		end else if (!chars_ok_q) begin
			chk_status = ST_BAD_CHAR;
		end else if (same_q && len_w == CMPW'(last_length_q) &&
				(ms_q - last_time_q) < {16'd0, cfg.dup_window_ms}) begin
			chk_status = ST_DUP;
		end else begin
			chk_status = ST_OK;
		end
	end

	always_comb begin
		state_d    = state_q;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		mem_waddr  = bank_addr(cur_bank, IW'(line_count_q));
		mem_raddr  = bank_addr(last_bank_q, IW'(line_count_q));
		cnt_inc    = 1'b0;
		bad_char   = 1'b0;
		same_clr   = 1'b0;
		clr_line   = 1'b0;
		commit     = 1'b0;
		walk_inc   = 1'b0;
		tick       = 1'b0;
		load_out   = 1'b0;
		out_status = ST_OK;
		out_char   = mem_rdata;
		out_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (accept && op) begin
					tick = 1'b1;
				end else if (accept && is_eol(rx_byte)) begin
					if (line_count_q != '0) begin
						state_d = S_LEND;
					end
				end else if (accept && is_printable(rx_byte) &&
						CMPW'(line_count_q) < CMPW'(LINE_LIMIT)) begin
					cnt_inc  = 1'b1;
					bad_char = !char_allowed(rx_byte);
					if (CMPW'(line_count_q) < CMPW'(CODE_DEPTH)) begin
						mem_we = 1'b1;
					end
					// compare against the stored code while it is long enough
					if (CMPW'(line_count_q) < CMPW'(last_length_q)) begin
						mem_re  = 1'b1;
						state_d = S_CMP;
					end else begin
						same_clr = 1'b1;
					end
				end
			end
			S_CMP: begin
				same_clr = (mem_rdata != byte_q);
				state_d  = S_IDLE;
			end
			S_LEND: begin
				if (chk_status != ST_OK) begin
					if (out_free) begin
						load_out   = 1'b1;
						out_status = chk_status;
						out_char   = 8'd0;
						clr_line   = 1'b1;
						state_d    = S_IDLE;
					end
				end else begin
					mem_re    = 1'b1;
					mem_raddr = bank_addr(cur_bank, IW'(walk_q));
					state_d   = S_WOUT;
				end
			end
			S_WOUT: begin
				if (out_free) begin
					load_out = 1'b1;
					out_last = walk_last;
					if (walk_last) begin
						commit   = 1'b1;
						clr_line = 1'b1;
						state_d  = S_IDLE;
					end else begin
						walk_inc  = 1'b1;
						mem_re    = 1'b1;
						mem_raddr = bank_addr(cur_bank, IW'(walk_nx));
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q  <= '0;
			chars_ok_q    <= 1'b1;
			same_q        <= 1'b1;
			last_bank_q   <= 1'b0;
			last_length_q <= '0;
			ms_q          <= '0;
			last_time_q   <= '0;
			walk_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (tick) begin
				ms_q <= ms_q + 32'd1;
			end
			if (clr_line) begin
				line_count_q <= '0;
				chars_ok_q   <= 1'b1;
				same_q       <= 1'b1;
				walk_q       <= '0;
			end else begin
				if (cnt_inc) begin
					line_count_q <= line_count_q + 1'b1;
				end
				if (bad_char) begin
					chars_ok_q <= 1'b0;
				end
				if (same_clr) begin
					same_q <= 1'b0;
				end
				if (walk_inc) begin
					walk_q <= walk_nx;
				end
			end
			if (commit) begin
				last_bank_q   <= cur_bank;
				last_length_q <= LLW'(line_count_q);
				last_time_q   <= ms_q;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= rx_byte;
		end
		if (load_out) begin
			status_q <= out_status;
			char_q   <= out_char;
			len_q    <= 8'(line_count_q);
			time_q   <= ms_q;
			last_q   <= out_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign code_char   = char_q;
	assign code_length = len_q;
	assign time_ms     = time_q;
	assign is_last     = last_q;

	`CLFD_ASSERT_ALWAYS(a_count_range, (CMPW'(line_count_q) <= CMPW'(LINE_LIMIT)) && (CMPW'(last_length_q) <= CMPW'(CODE_DEPTH)), "line or last code length out of range")

	`CLFD_ASSERT_ALWAYS(a_status_shape, !(out_valid_q && status_q != ST_OK) || (char_q == 8'd0 && last_q), "status result carries a character or is not last")

	`CLFD_ASSERT_NEXT(a_commit, state_q == S_WOUT && out_free && walk_last, last_length_q == $past(LLW'(line_count_q)) && line_count_q == '0 && last_bank_q != $past(last_bank_q), "accepted code not committed")

	`CLFD_ASSERT_ALWAYS(a_cmp_entry, state_q != S_CMP || $past(accept && !op), "compare without a byte request")

endmodule

### design/code_line_filter_dedup.sv
// ----------------------------------------------------------------------------
// code_line_filter_dedup
// scanner line filter: collects printable bytes, checks length and character
// set, suppresses repeats of the last code and streams accepted codes out
// ----------------------------------------------------------------------------
//
// channel | signals                                       | direction
// --------+-----------------------------------------------+----------
// in      | in_valid, in_ready, op, rx_byte               | request in
// out     | out_valid, out_ready, status, code_char,      | request out
//         | code_length, time_ms, is_last                 |
// cfg     | cfg_we, cfg_index, cfg_data                   | write in
//
// a tick or a byte not compared to the stored code is taken in the idle state
// a byte within the length of the last code reads the code bank memory, then
//   compares against the stored character in the compare state
// a line end is taken as the request, then checked; an accepted code then
//   streams out one character per cycle, set by the single memory read port;
//   slower while out stalls
// reset clears all control state; the code banks need no clearing pass
// a stalled out request holds in the output register; in stays ready while idle
module code_line_filter_dedup #(
	parameter int CODE_DEPTH = clfd_pkg::CODE_DEPTH_DEF,
	parameter int LINE_LIMIT = clfd_pkg::LINE_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        op,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [7:0]  code_char,
	output logic [7:0]  code_length,
	output logic [31:0] time_ms,
	output logic        is_last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import clfd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dup_window_ms <= DUP_WINDOW_RST;
			cfg_q.min_length    <= MIN_LEN_RST;
			cfg_q.max_length    <= MAX_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DUP_WINDOW: cfg_q.dup_window_ms <= cfg_data;
				REG_MIN_LEN:    cfg_q.min_length    <= cfg_data[6:0];
				REG_MAX_LEN:    cfg_q.max_length    <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	clfd_core #(
		.CODE_DEPTH (CODE_DEPTH),
		.LINE_LIMIT (LINE_LIMIT)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.code_char   (code_char),
		.code_length (code_length),
		.time_ms     (time_ms),
		.is_last     (is_last)
	);

endmodule
